### rtl/core/hpds_pkg.sv
// ----------------------------------------------------------------------------
// hpds_pkg
// Shared types, widths and constants of the heading PD steering block.
// ----------------------------------------------------------------------------
package hpds_pkg;

  localparam int ANG_W   = 16;                 // binary angle, 32768 = pi
  localparam int GAIN_W  = 16;                 // Q4.12 gains
  localparam int CRD_W   = 28;                 // CORDIC x/y datapath
  localparam int PHS_W   = 18;                 // CORDIC angle accumulator
  localparam int ITERS   = 16;
  localparam int CNT_W   = 4;
  localparam int MUL_W   = ANG_W + 1;          // signed multiplier operands
  localparam int PRD_W   = 2 * MUL_W;
  localparam int SUM_W   = PRD_W + 1;
  localparam int FRAC_SH = 12;
  localparam int SAT_W   = SUM_W - FRAC_SH;

  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd16085;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd7721;

  localparam logic signed [PHS_W-1:0] QUARTER_TURN = 18'sd16384;
  localparam logic signed [SAT_W-1:0] SAT_POS      = 23'sd16384;
  localparam logic signed [SAT_W-1:0] SAT_NEG      = -23'sd16384;

  // register map, indexed by paddr[2]
  typedef enum logic {
    REG_PROP_GAIN  = 1'b0,
    REG_DERIV_GAIN = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CORDIC = 4'b0010,
    ST_PD     = 4'b0100,
    ST_HOLD   = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] dir_x;
    logic signed [ANG_W-1:0] dir_z;
  } crd_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } crd_res_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] err;
  } pd_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] correction;
  } pd_res_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
  } gains_t;

  // arctan(2^-i) in binary-angle units
  function automatic logic signed [PHS_W-1:0] atan_lut(input logic [CNT_W-1:0] idx);
    logic signed [PHS_W-1:0] v;
    case (idx)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      4'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/hpds_in_if.sv
// ----------------------------------------------------------------------------
// hpds_in_if
// Input channel: target direction and current heading.
// ----------------------------------------------------------------------------
interface hpds_in_if import hpds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] dir_x;
  logic signed [ANG_W-1:0] dir_z;
  logic signed [ANG_W-1:0] heading;

  modport source (output valid, dir_x, dir_z, heading, input ready);
  modport sink   (input valid, dir_x, dir_z, heading, output ready);
endinterface

### rtl/core/hpds_out_if.sv
// ----------------------------------------------------------------------------
// hpds_out_if
// Result channel: saturated steering correction, Q1.14.
// ----------------------------------------------------------------------------
interface hpds_out_if import hpds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] correction;

  modport source (output valid, correction, input ready);
  modport sink   (input valid, correction, output ready);
endinterface

### rtl/core/hpds_cfg.sv
// ----------------------------------------------------------------------------
// hpds_cfg
// APB register file holding the proportional and derivative gains.
// ----------------------------------------------------------------------------
module hpds_cfg import hpds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output gains_t            gains
);

  logic [GAIN_W-1:0] prop_r,  prop_nxt;
  logic [GAIN_W-1:0] deriv_r, deriv_nxt;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    prop_nxt  = prop_r;
    deriv_nxt = deriv_r;
    if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:  prop_nxt  = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_nxt = pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r  <= PROP_GAIN_RST;
      deriv_r <= DERIV_GAIN_RST;
    end else begin
      prop_r  <= prop_nxt;
      deriv_r <= deriv_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:  prdata = {{(APB_DW-GAIN_W){1'b0}}, prop_r};
      REG_DERIV_GAIN: prdata = {{(APB_DW-GAIN_W){1'b0}}, deriv_r};
      default:        prdata = '0;
    endcase
  end

  assign gains.prop_gain  = prop_r;
  assign gains.deriv_gain = deriv_r;

endmodule

### rtl/core/hpds_cordic.sv
// ----------------------------------------------------------------------------
// hpds_cordic
// Vectoring CORDIC, one micro-rotation per cycle, gives atan2(x, z) as a
// 16-bit binary angle.
// ----------------------------------------------------------------------------
module hpds_cordic import hpds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  crd_req_t req,
  output crd_res_t res
);

  logic signed [CRD_W-1:0] cx_r, cx_nxt;
  logic signed [CRD_W-1:0] cy_r, cy_nxt;
  logic signed [PHS_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic                    zero_r, zero_nxt;

  logic signed [CRD_W-1:0] x_ext, z_ext, dx, dy;

  // inputs scaled by 256 for headroom in the fractional bits
  assign x_ext = {{(CRD_W-ANG_W-8){req.dir_x[ANG_W-1]}}, req.dir_x, 8'd0};
  assign z_ext = {{(CRD_W-ANG_W-8){req.dir_z[ANG_W-1]}}, req.dir_z, 8'd0};

  assign dx = cy_r >>> cnt_r;
  assign dy = cx_r >>> cnt_r;

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      zero_nxt = (req.dir_x == '0) && (req.dir_z == '0);
      if (z_ext < 0) begin
        // rotate into the right half-plane first
        if (x_ext >= 0) begin
          cx_nxt  = x_ext;
          cy_nxt  = -z_ext;
          acc_nxt = QUARTER_TURN;
        end else begin
          cx_nxt  = -x_ext;
          cy_nxt  = z_ext;
          acc_nxt = -QUARTER_TURN;
        end
      end else begin
        cx_nxt  = z_ext;
        cy_nxt  = x_ext;
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      if (cy_r > 0) begin
        cx_nxt  = cx_r + dx;
        cy_nxt  = cy_r - dy;
        acc_nxt = acc_r + atan_lut(cnt_r);
      end else begin
        cx_nxt  = cx_r - dx;
        cy_nxt  = cy_r + dy;
        acc_nxt = acc_r - atan_lut(cnt_r);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    acc_r  <= acc_nxt;
    zero_r <= zero_nxt;
  end

  assign res.done  = done_r;
  assign res.angle = zero_r ? '0 : acc_r[ANG_W-1:0];

`ifndef NO_ASSERTIONS
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("cordic done without a finished run");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start |=> busy_r || done_r)
    else $error("cordic run dropped before the last micro-rotation");
`endif

endmodule

### rtl/core/hpds_pd.sv
// ----------------------------------------------------------------------------
// hpds_pd
// PD term on one shared 17x17 signed multiplier: two products, summed,
// floored by 12 bits and clamped to +/-1.0 Q1.14. Holds the previous error.
// ----------------------------------------------------------------------------
module hpds_pd import hpds_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  gains_t  gains,
  input  pd_req_t req,
  output pd_res_t res
);

  logic signed [ANG_W-1:0] err_r, err_nxt;
  logic signed [ANG_W-1:0] prev_r, prev_nxt;
  logic signed [PRD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [ANG_W-1:0] corr_r, corr_nxt;
  logic [2:0]              step_r, step_nxt;  // one-hot: P product, D product, sum
  logic                    done_r, done_nxt;

  logic signed [MUL_W-1:0] diff, mul_a, mul_b;
  logic signed [PRD_W-1:0] mul_p;
  logic signed [SUM_W-1:0] sum;
  logic signed [SAT_W-1:0] scaled;

  assign diff  = {err_r[ANG_W-1], err_r} - {prev_r[ANG_W-1], prev_r};
  assign mul_a = step_r[0] ? {err_r[ANG_W-1], err_r} : diff;
  assign mul_b = step_r[0] ? {1'b0, gains.prop_gain} : {1'b0, gains.deriv_gain};
  assign mul_p = mul_a * mul_b;

  assign sum    = acc_r + {prod_r[PRD_W-1], prod_r};
  assign scaled = sum[SUM_W-1:FRAC_SH];   // floor shift

  always_comb begin
    err_nxt  = err_r;
    prev_nxt = prev_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    corr_nxt = corr_r;
    step_nxt = {step_r[1:0], 1'b0};
    done_nxt = 1'b0;
    if (req.start) begin
      err_nxt  = req.err;
      step_nxt = 3'b001;
    end
    if (step_r[0]) begin
      prod_nxt = mul_p;
    end
    if (step_r[1]) begin
      acc_nxt  = {prod_r[PRD_W-1], prod_r};
      prod_nxt = mul_p;
    end
    if (step_r[2]) begin
      if (scaled > SAT_POS) begin
        corr_nxt = SAT_POS[ANG_W-1:0];
      end else if (scaled < SAT_NEG) begin
        corr_nxt = SAT_NEG[ANG_W-1:0];
      end else begin
        corr_nxt = scaled[ANG_W-1:0];
      end
      prev_nxt = err_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    corr_r <= corr_nxt;
  end

  assign res.done       = done_r;
  assign res.correction = corr_r;

`ifndef NO_ASSERTIONS
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(step_r))
    else $error("pd step sequencer not one-hot");
  a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> prev_r == err_r)
    else $error("previous error not updated with the result");
`endif

endmodule

### rtl/core/heading_pd_steering_top.sv
// ----------------------------------------------------------------------------
// heading_pd_steering_top
// PD heading controller: CORDIC atan2 target angle, wrapped heading error,
// proportional plus derivative term, saturated Q1.14 correction.
//
//   channel  direction  payload                        transfer when
//   in_ch    sink       dir_x, dir_z, heading (s16)    valid & ready
//   out_ch   source     correction (s16, Q1.14)        valid & ready
//   apb      slave      gains at 0x0 / 0x4 (u16 Q4.12) psel & penable & pwrite
//
// From input transfer to result valid: the pre-rotation is loaded at the
// transfer edge, then come 16 CORDIC micro-rotations, one error capture,
// three PD steps and the output register load.
// in_ch.ready is high only while idle.
// The output register lets the next item start while a result waits; a
// result that finds it still full is held until out_ch drains.
// Synchronous active-low reset; gains return to defaults, previous error to 0.
// ----------------------------------------------------------------------------
module heading_pd_steering_top import hpds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hpds_in_if.sink           in_ch,
  hpds_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  seq_state_t              st_r, st_nxt;
  logic signed [ANG_W-1:0] heading_r, heading_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [ANG_W-1:0] out_data_r, out_data_nxt;

  gains_t   gains;
  crd_req_t crd_req;
  crd_res_t crd_res;
  pd_req_t  pd_req;
  pd_res_t  pd_res;
  logic     in_xfer, out_free, load_out;

  hpds_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;

  assign crd_req.start = in_xfer;
  assign crd_req.dir_x = in_ch.dir_x;
  assign crd_req.dir_z = in_ch.dir_z;

  hpds_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (crd_req),
    .res   (crd_res)
  );

  // error wraps modulo one turn
  assign pd_req.start = crd_res.done;
  assign pd_req.err   = crd_res.angle - heading_r;

  hpds_pd u_pd (
    .clk   (clk),
    .rst_n (rst_n),
    .gains (gains),
    .req   (pd_req),
    .res   (pd_res)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = out_free && (((st_r == ST_PD) && pd_res.done) || (st_r == ST_HOLD));

  always_comb begin
    st_nxt        = st_r;
    heading_nxt   = heading_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_xfer) begin
      heading_nxt = in_ch.heading;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pd_res.correction;
    end
    case (st_r)
      ST_IDLE:   if (in_xfer) st_nxt = ST_CORDIC;
      ST_CORDIC: if (crd_res.done) st_nxt = ST_PD;
      ST_PD: begin
        if (pd_res.done) st_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD:   if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    heading_r  <= heading_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.correction = out_data_r;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> st_r == ST_CORDIC)
    else $error("accepted item did not start the CORDIC");
  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    crd_res.done |-> st_r == ST_CORDIC)
    else $error("CORDIC result outside its sequencer state");
  a_pd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    pd_res.done |-> st_r == ST_PD)
    else $error("PD result outside its sequencer state");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r <= $signed(SAT_POS[ANG_W-1:0])
                 && out_data_r >= $signed(SAT_NEG[ANG_W-1:0]))
    else $error("correction outside the saturation limits");
`endif

endmodule

### tb/sv/heading_pd_steering_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_pd_steering_top_tb
// Self-checking bench for the heading PD steering block. A queue-fed driver
// and a clocked monitor exercise the input and result channels with random
// gaps on both sides. Every accepted item is run through a local atan2 plus
// PD predictor and the expected correction is compared with each result.
// Gains are rewritten over APB between drained phases, extremes included.
// ----------------------------------------------------------------------------
module heading_pd_steering_top_tb import hpds_pkg::*; ();

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 25;   // margin over one item's run through the block

  // arctan(2^-i), binary angle units
  localparam int ATAN_STEP [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct packed {
    logic signed [ANG_W-1:0] dir_x;
    logic signed [ANG_W-1:0] dir_z;
    logic signed [ANG_W-1:0] heading;
  } steer_item_t;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  hpds_in_if  in_ch ();
  hpds_out_if out_ch ();

  heading_pd_steering_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and gain copies
  logic [GAIN_W-1:0]       kp_gain  = PROP_GAIN_RST;
  logic [GAIN_W-1:0]       kd_gain  = DERIV_GAIN_RST;
  logic signed [ANG_W-1:0] last_err = '0;

  steer_item_t             item_q[$];
  logic signed [ANG_W-1:0] corr_q[$];
  steer_item_t             send_item;
  logic signed [ANG_W-1:0] want_corr;
  int                      send_gap  = 0;
  int                      hold_cnt  = 0;
  int                      fail_cnt  = 0;
  int                      cycle_cnt = 0;
  bit                      send_idle = 1'b1;
  bit                      recv_idle = 1'b1;

  // CORDIC vectoring atan2(x, z) as a 16-bit binary angle
  function automatic logic signed [ANG_W-1:0] target_angle(input logic signed [ANG_W-1:0] x,
                                                           input logic signed [ANG_W-1:0] z);
    int re, im, acc, t, dre, dim, i;
    if (x == 0 && z == 0) return '0;
    re  = int'(z) * 256;
    im  = int'(x) * 256;
    acc = 0;
    if (re < 0) begin
      t = re;
      if (im >= 0) begin
        re  = im;
        im  = -t;
        acc = 16384;
      end else begin
        re  = -im;
        im  = t;
        acc = -16384;
      end
    end
    for (i = 0; i < 16; i++) begin
      dre = im >>> i;
      dim = re >>> i;
      if (im > 0) begin
        re  += dre;
        im  -= dim;
        acc += ATAN_STEP[i];
      end else begin
        re  -= dre;
        im  += dim;
        acc -= ATAN_STEP[i];
      end
    end
    return acc[ANG_W-1:0];
  endfunction

  // PD term on the wrapped error; updates the stored error
  function automatic logic signed [ANG_W-1:0] steer_correction(input steer_item_t it);
    logic signed [ANG_W-1:0] err;
    longint                  delta, pd;
    err   = target_angle(it.dir_x, it.dir_z) - it.heading;
    delta = longint'(err) - longint'(last_err);
    pd    = longint'(err) * longint'(kp_gain) + delta * longint'(kd_gain);
    pd    = pd >>> FRAC_SH;
    if (pd > 16384) pd = 16384;
    if (pd < -16384) pd = -16384;
    last_err = err;
    return pd[ANG_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [ANG_W-1:0] pick_corner();
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic steer_item_t make_item();
    steer_item_t it;
    int          r, off;
    r          = $urandom_range(0, 99);
    it.dir_x   = ANG_W'($urandom);
    it.dir_z   = ANG_W'($urandom);
    it.heading = ANG_W'($urandom);
    off        = int'($urandom_range(0, 1200)) - 600;
    if (r < 35) begin
      // heading close to target: small errors, little saturation
      it.heading = ANG_W'(int'(target_angle(it.dir_x, it.dir_z)) - off);
    end else if (r < 65) begin
      // fully random fields
    end else if (r < 80) begin
      it.dir_x = ANG_W'(int'($urandom_range(0, 8)) - 4);
      it.dir_z = ANG_W'(int'($urandom_range(0, 8)) - 4);
      if (r < 72) it.heading = ANG_W'(int'(target_angle(it.dir_x, it.dir_z)) - off);
    end else if (r < 90) begin
      if (r & 1) it.dir_x = pick_corner();
      else it.dir_z = pick_corner();
    end else begin
      // error near pi, either side of the wrap
      it.heading = ANG_W'(int'(target_angle(it.dir_x, it.dir_z)) + 32768 + off / 64);
    end
    return it;
  endfunction

  task automatic queue_item(input int x, input int z, input int h);
    item_q.push_back('{ANG_W'(x), ANG_W'(z), ANG_W'(h)});
  endtask

  task automatic queue_random(input int n);
    repeat (n) item_q.push_back(make_item());
  endtask

  // wait until every sent item has produced its result, then let the block settle;
  // checked mid-cycle so that the driver's pop and its valid are seen together
  task automatic drain();
    while (item_q.size() != 0 || in_ch.valid || corr_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gain(input reg_idx_t idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};   // upper bits are don't-care
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp_gain = val;
      REG_DERIV_GAIN: kd_gain = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd);
    write_gain(REG_PROP_GAIN, kp);
    write_gain(REG_DERIV_GAIN, kd);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (item_q.size() > 0) begin
        send_item     = item_q.pop_front();
        in_ch.dir_x   <= send_item.dir_x;
        in_ch.dir_z   <= send_item.dir_z;
        in_ch.heading <= send_item.heading;
        in_ch.valid   <= 1'b1;
        send_gap      = send_idle ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt     = 0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt--;
    end else begin
      out_ch.ready <= 1'b1;
      hold_cnt     = recv_idle ? pick_gap() : 0;
    end
  end

  // monitor: check results, predict on each input transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (corr_q.size() == 0) begin
          $error("correction: no result expected, actual %0d", out_ch.correction);
          fail_cnt++;
        end else begin
          want_corr = corr_q.pop_front();
          if (out_ch.correction !== want_corr) begin
            $error("correction: expected %0d, actual %0d", want_corr, out_ch.correction);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        corr_q.push_back(steer_correction('{in_ch.dir_x, in_ch.dir_z, in_ch.heading}));
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.dir_x   = '0;
    in_ch.dir_z   = '0;
    in_ch.heading = '0;
    out_ch.ready  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset gains
    queue_item(0, 0, 0);                 // zero vector
    queue_item(0, 0, -32768);            // zero vector, error of pi
    queue_item(0, 1, -32768);            // target 0, error wraps to -pi
    queue_item(0, 1, 16384);             // large negative error, saturates
    queue_item(0, 1, -16384);            // large positive error, saturates
    queue_item(32767, 0, 32767);
    queue_item(-32768, 0, -32768);
    queue_item(0, 32767, 0);
    queue_item(0, -32768, 0);            // target at pi
    queue_item(0, -5, 32767);
    queue_item(-32768, -32768, 0);       // left rear quadrant
    queue_item(32767, -32768, 0);        // right rear quadrant
    queue_item(-32768, 32767, 100);
    queue_item(32767, 32767, 8192);
    queue_item(-1, -1, 0);
    queue_item(1, -1, 0);
    queue_item(1, 1, 8190);              // small errors, both terms unsaturated
    queue_item(1, 1, 8195);
    queue_item(1, 1, 8192);
    queue_item(-3, 2, 0);
    queue_item(-21846, 10923, -21846);
    queue_random(120);
    drain();

    send_idle = 1'b0;
    set_gains(16'd0, 16'd0);
    queue_random(100);
    drain();

    recv_idle = 1'b1;
    set_gains(16'hFFFF, 16'hFFFF);
    queue_random(120);
    drain();

    send_idle = 1'b1;
    recv_idle = 1'b0;
    set_gains(16'd0, 16'hFFFF);
    queue_random(120);
    drain();

    recv_idle = 1'b1;
    set_gains(16'hFFFF, 16'd0);
    queue_random(120);
    drain();

    // low gains keep most results off the rails, so rounding shows
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_gains(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
    queue_random(150);
    drain();

    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_gains(16'($urandom), 16'($urandom));
    queue_random(150);
    drain();

    set_gains(PROP_GAIN_RST, DERIV_GAIN_RST);
    queue_random(150);
    drain();

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
